FILE: rtl/yrgb_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and coefficient helper for the yuyv to rgb converter
// no dependencies

package yrgb_pkg;

  localparam int COEF_FRAC_BITS_DEF = 8;

  // coefficients in thousandths
  localparam int COEF_R_MILLI  = 1402;
  localparam int COEF_B_MILLI  = 1772;
  localparam int COEF_GU_MILLI = 344;
  localparam int COEF_GV_MILLI = 714;

  localparam logic [7:0] CHANNEL_MAX = 8'hFF;

  typedef logic [1:0] lane_t;

  typedef struct packed {
    lane_t red;
    lane_t green;
    lane_t blue;
  } lane_cfg_t;

  typedef enum logic [1:0] {
    CFG_RED_LANE   = 2'd0,
    CFG_GREEN_LANE = 2'd1,
    CFG_BLUE_LANE  = 2'd2
  } cfg_idx_e;

  localparam lane_cfg_t LANE_CFG_RESET = '{red: 2'd2, green: 2'd1, blue: 2'd0};

  // round(milli / 1000 * 2^frac), evaluated at elaboration
  function automatic int coef_fix(input int milli, input int frac);
    return ((milli << frac) + 500) / 1000;
  endfunction

endpackage

FILE: rtl/yrgb_mult.sv
`timescale 1ns / 1ps
// first pipeline stage: chroma offset removal and the four coefficient products
// depends on yrgb_pkg

module yrgb_mult #(
  parameter int COEF_FRAC_BITS = yrgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          luma_first_i,
  input  logic [7:0]                          chroma_blue_i,
  input  logic [7:0]                          luma_second_i,
  input  logic [7:0]                          chroma_red_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          luma_first_o,
  output logic [7:0]                          luma_second_o,
  output logic signed [COEF_FRAC_BITS+10:0]   prod_r_o,
  output logic signed [COEF_FRAC_BITS+10:0]   prod_b_o,
  output logic signed [COEF_FRAC_BITS+10:0]   prod_gu_o,
  output logic signed [COEF_FRAC_BITS+10:0]   prod_gv_o
);

  localparam int PROD_W = COEF_FRAC_BITS + 11;
  localparam int KW     = COEF_FRAC_BITS + 2;

  localparam logic signed [KW-1:0] KR  =
    KW'(yrgb_pkg::coef_fix(yrgb_pkg::COEF_R_MILLI, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KB  =
    KW'(yrgb_pkg::coef_fix(yrgb_pkg::COEF_B_MILLI, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KGU =
    KW'(yrgb_pkg::coef_fix(yrgb_pkg::COEF_GU_MILLI, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KGV =
    KW'(yrgb_pkg::coef_fix(yrgb_pkg::COEF_GV_MILLI, COEF_FRAC_BITS));

  logic                     valid_q, valid_d;
  logic                     load;
  logic signed [7:0]        cb_s, cr_s;
  logic signed [PROD_W-1:0] prod_r_d, prod_b_d, prod_gu_d, prod_gv_d;
  logic signed [PROD_W-1:0] prod_r_q, prod_b_q, prod_gu_q, prod_gv_q;
  logic [7:0]               luma_first_q, luma_second_q;

  // subtracting 128 from an unsigned byte flips its top bit
  assign cb_s = signed'({~chroma_blue_i[7], chroma_blue_i[6:0]});
  assign cr_s = signed'({~chroma_red_i[7], chroma_red_i[6:0]});

  assign prod_r_d  = PROD_W'(KR)  * PROD_W'(cr_s);
  assign prod_b_d  = PROD_W'(KB)  * PROD_W'(cb_s);
  assign prod_gu_d = PROD_W'(KGU) * PROD_W'(cb_s);
  assign prod_gv_d = PROD_W'(KGV) * PROD_W'(cr_s);

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      luma_first_q  <= luma_first_i;
      luma_second_q <= luma_second_i;
      prod_r_q      <= prod_r_d;
      prod_b_q      <= prod_b_d;
      prod_gu_q     <= prod_gu_d;
      prod_gv_q     <= prod_gv_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign luma_first_o  = luma_first_q;
  assign luma_second_o = luma_second_q;
  assign prod_r_o      = prod_r_q;
  assign prod_b_o      = prod_b_q;
  assign prod_gu_o     = prod_gu_q;
  assign prod_gv_o     = prod_gv_q;

endmodule

FILE: rtl/yrgb_sum.sv
`timescale 1ns / 1ps
// second pipeline stage: luma plus chroma terms for both pixels of the pair
// depends on yrgb_pkg for the default fraction width

module yrgb_sum #(
  parameter int COEF_FRAC_BITS = yrgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        luma_first_i,
  input  logic [7:0]                        luma_second_i,
  input  logic signed [COEF_FRAC_BITS+10:0] prod_r_i,
  input  logic signed [COEF_FRAC_BITS+10:0] prod_b_i,
  input  logic signed [COEF_FRAC_BITS+10:0] prod_gu_i,
  input  logic signed [COEF_FRAC_BITS+10:0] prod_gv_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [COEF_FRAC_BITS+10:0] sum_r0_o,
  output logic signed [COEF_FRAC_BITS+10:0] sum_g0_o,
  output logic signed [COEF_FRAC_BITS+10:0] sum_b0_o,
  output logic signed [COEF_FRAC_BITS+10:0] sum_r1_o,
  output logic signed [COEF_FRAC_BITS+10:0] sum_g1_o,
  output logic signed [COEF_FRAC_BITS+10:0] sum_b1_o
);

  localparam int SUM_W = COEF_FRAC_BITS + 11;

  logic                    valid_q, valid_d;
  logic                    load;
  logic signed [SUM_W-1:0] base0, base1;
  logic signed [SUM_W-1:0] r0_d, g0_d, b0_d, r1_d, g1_d, b1_d;
  logic signed [SUM_W-1:0] r0_q, g0_q, b0_q, r1_q, g1_q, b1_q;

  assign base0 = signed'(SUM_W'({luma_first_i, {COEF_FRAC_BITS{1'b0}}}));
  assign base1 = signed'(SUM_W'({luma_second_i, {COEF_FRAC_BITS{1'b0}}}));

  assign r0_d = base0 + prod_r_i;
  assign g0_d = base0 - prod_gu_i - prod_gv_i;
  assign b0_d = base0 + prod_b_i;
  assign r1_d = base1 + prod_r_i;
  assign g1_d = base1 - prod_gu_i - prod_gv_i;
  assign b1_d = base1 + prod_b_i;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      r0_q <= r0_d;
      g0_q <= g0_d;
      b0_q <= b0_d;
      r1_q <= r1_d;
      g1_q <= g1_d;
      b1_q <= b1_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sum_r0_o    = r0_q;
  assign sum_g0_o    = g0_q;
  assign sum_b0_o    = b0_q;
  assign sum_r1_o    = r1_q;
  assign sum_g1_o    = g1_q;
  assign sum_b1_o    = b1_q;

endmodule

FILE: rtl/yrgb_pack.sv
`timescale 1ns / 1ps
// third pipeline stage: floor, clamp to a byte and place channels in lanes
// depends on yrgb_pkg for the lane configuration type

module yrgb_pack #(
  parameter int COEF_FRAC_BITS = yrgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  yrgb_pkg::lane_cfg_t               lane_cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COEF_FRAC_BITS+10:0] sum_r0_i,
  input  logic signed [COEF_FRAC_BITS+10:0] sum_g0_i,
  input  logic signed [COEF_FRAC_BITS+10:0] sum_b0_i,
  input  logic signed [COEF_FRAC_BITS+10:0] sum_r1_i,
  input  logic signed [COEF_FRAC_BITS+10:0] sum_g1_i,
  input  logic signed [COEF_FRAC_BITS+10:0] sum_b1_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [31:0]                       pixel_first_o,
  output logic [31:0]                       pixel_second_o
);

  localparam int SUM_W = COEF_FRAC_BITS + 11;

  logic        valid_q, valid_d;
  logic        load;
  logic [7:0]  r0, g0, b0, r1, g1, b1;
  logic [31:0] pix0_d, pix1_d;
  logic [31:0] pix0_q, pix1_q;

  function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = 8'h00;
    end else if (|s[SUM_W-2:COEF_FRAC_BITS+8]) begin
      res = yrgb_pkg::CHANNEL_MAX;
    end else begin
      res = s[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    return res;
  endfunction

  assign r0 = clamp_byte(sum_r0_i);
  assign g0 = clamp_byte(sum_g0_i);
  assign b0 = clamp_byte(sum_b0_i);
  assign r1 = clamp_byte(sum_r1_i);
  assign g1 = clamp_byte(sum_g1_i);
  assign b1 = clamp_byte(sum_b1_i);

  // blue wins over green, green over red
  always_comb begin
    pix0_d = '0;
    pix1_d = '0;
    for (int n = 0; n < 4; n++) begin
      if (lane_cfg_i.blue == yrgb_pkg::lane_t'(n)) begin
        pix0_d[8*n +: 8] = b0;
        pix1_d[8*n +: 8] = b1;
      end else if (lane_cfg_i.green == yrgb_pkg::lane_t'(n)) begin
        pix0_d[8*n +: 8] = g0;
        pix1_d[8*n +: 8] = g1;
      end else if (lane_cfg_i.red == yrgb_pkg::lane_t'(n)) begin
        pix0_d[8*n +: 8] = r0;
        pix1_d[8*n +: 8] = r1;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix0_q <= pix0_d;
      pix1_q <= pix1_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign pixel_first_o  = pix0_q;
  assign pixel_second_o = pix1_q;

endmodule

FILE: rtl/yuyv_to_rgb_pixel_pair_top.sv
`timescale 1ns / 1ps
// Converts one YUYV 4:2:2 group per transaction into two full-range BT.601 RGB
// pixels in 32-bit words, with red, green and blue in configurable byte lanes
// (blue wins over green and green over red where lanes coincide, other lanes
// are zero). A new pair is taken every clock unless the sink stalls. The
// datapath has three register stages: coefficient multiply, channel sum, and
// clamp with lane packing, which each pair passes through in that order.
// The user must write lane registers through the cfg port only while no pair
// is in flight; the block itself does not enforce this.
// depends on yrgb_pkg, yrgb_mult, yrgb_sum and yrgb_pack

module yuyv_to_rgb_pixel_pair_top #(
  parameter int COEF_FRAC_BITS = yrgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // luma_first, chroma_blue, luma_second, chroma_red
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_first, pixel_second
  output logic [63:0] m_axis_tdata
);

  localparam int SUM_W = COEF_FRAC_BITS + 11;

  yrgb_pkg::lane_cfg_t lane_q, lane_d;

  logic                    v1, v2;
  logic                    rdy2, rdy3;
  logic [7:0]              y0_s1, y1_s1;
  logic signed [SUM_W-1:0] pr_s1, pb_s1, pgu_s1, pgv_s1;
  logic signed [SUM_W-1:0] r0_s2, g0_s2, b0_s2, r1_s2, g1_s2, b1_s2;

  always_comb begin
    lane_d = lane_q;
    if (cfg_we_i) begin
      unique case (yrgb_pkg::cfg_idx_e'(cfg_idx_i))
        yrgb_pkg::CFG_RED_LANE:   lane_d.red   = cfg_data_i;
        yrgb_pkg::CFG_GREEN_LANE: lane_d.green = cfg_data_i;
        yrgb_pkg::CFG_BLUE_LANE:  lane_d.blue  = cfg_data_i;
        default:                  lane_d       = lane_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= yrgb_pkg::LANE_CFG_RESET;
    end else begin
      lane_q <= lane_d;
    end
  end

  yrgb_mult #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mult (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .luma_first_i  (s_axis_tdata[7:0]),
    .chroma_blue_i (s_axis_tdata[15:8]),
    .luma_second_i (s_axis_tdata[23:16]),
    .chroma_red_i  (s_axis_tdata[31:24]),
    .out_valid_o   (v1),
    .out_ready_i   (rdy2),
    .luma_first_o  (y0_s1),
    .luma_second_o (y1_s1),
    .prod_r_o      (pr_s1),
    .prod_b_o      (pb_s1),
    .prod_gu_o     (pgu_s1),
    .prod_gv_o     (pgv_s1)
  );

  yrgb_sum #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v1),
    .in_ready_o    (rdy2),
    .luma_first_i  (y0_s1),
    .luma_second_i (y1_s1),
    .prod_r_i      (pr_s1),
    .prod_b_i      (pb_s1),
    .prod_gu_i     (pgu_s1),
    .prod_gv_i     (pgv_s1),
    .out_valid_o   (v2),
    .out_ready_i   (rdy3),
    .sum_r0_o      (r0_s2),
    .sum_g0_o      (g0_s2),
    .sum_b0_o      (b0_s2),
    .sum_r1_o      (r1_s2),
    .sum_g1_o      (g1_s2),
    .sum_b1_o      (b1_s2)
  );

  yrgb_pack #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_pack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lane_cfg_i     (lane_q),
    .in_valid_i     (v2),
    .in_ready_o     (rdy3),
    .sum_r0_i       (r0_s2),
    .sum_g0_i       (g0_s2),
    .sum_b0_i       (b0_s2),
    .sum_r1_i       (r1_s2),
    .sum_g1_i       (g1_s2),
    .sum_b1_i       (b1_s2),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .pixel_first_o  (m_axis_tdata[31:0]),
    .pixel_second_o (m_axis_tdata[63:32])
  );

  // a ready sink never back-pressures the source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

  // a full pipeline with a stalled sink takes nothing more
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1 && v2 && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("full pipeline accepted a transaction");

  // with the sink ready, an accepted pair is not lost and reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready)
      |=> m_axis_tvalid)
    else $error("transaction lost in pipeline");

  // stage two only fills from stage one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1 && !v2) |=> !v2)
    else $error("stage two valid without source");

endmodule

FILE: test/tb_yuyv_to_rgb_pixel_pair_top.sv
`timescale 1ns / 1ps
// self-checking testbench for yuyv_to_rgb_pixel_pair_top: yuyv pairs under several lane settings
// with random sender gaps and receiver stalls, checked against a fixed-point bt.601 predictor
// depends on yrgb_pkg and the converter rtl

module tb_yuyv_to_rgb_pixel_pair_top;

  localparam int FRAC = yrgb_pkg::COEF_FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int PAIRS_PER_PHASE = 210;
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

  class rgb_pair_scoreboard;
    localparam int RED_K = (yrgb_pkg::COEF_R_MILLI * (1 << FRAC) + 500) / 1000;
    localparam int BLUE_K = (yrgb_pkg::COEF_B_MILLI * (1 << FRAC) + 500) / 1000;
    localparam int GREEN_CB_K = (yrgb_pkg::COEF_GU_MILLI * (1 << FRAC) + 500) / 1000;
    localparam int GREEN_CR_K = (yrgb_pkg::COEF_GV_MILLI * (1 << FRAC) + 500) / 1000;

    yrgb_pkg::lane_cfg_t lanes = yrgb_pkg::LANE_CFG_RESET;
    logic [63:0] expected_pixels[$];
    int errors = 0;

    function void set_lane(logic [1:0] idx, yrgb_pkg::lane_t value);
      case (idx)
        yrgb_pkg::CFG_RED_LANE: lanes.red = value;
        yrgb_pkg::CFG_GREEN_LANE: lanes.green = value;
        yrgb_pkg::CFG_BLUE_LANE: lanes.blue = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp_channel(int acc);
      int whole;
      if (acc < 0) return 8'd0;
      whole = acc >>> FRAC;
      return (whole > 255) ? yrgb_pkg::CHANNEL_MAX : whole[7:0];
    endfunction

    function logic [31:0] rgb_word(logic [7:0] luma, int cb, int cr);
      int base;
      logic [31:0] word;
      base = int'(luma) * (1 << FRAC);
      word = '0;
      word[8 * lanes.red +: 8] = clamp_channel(base + RED_K * cr);
      word[8 * lanes.green +: 8] = clamp_channel(base - GREEN_CB_K * cb - GREEN_CR_K * cr);
      word[8 * lanes.blue +: 8] = clamp_channel(base + BLUE_K * cb);
      return word;
    endfunction

    function void note_pair(logic [31:0] yuyv);
      int cb;
      int cr;
      cb = int'(yuyv[15:8]) - 128;
      cr = int'(yuyv[31:24]) - 128;
      expected_pixels.push_back({rgb_word(yuyv[23:16], cb, cr), rgb_word(yuyv[7:0], cb, cr)});
    endfunction

    function void check_pixels(logic [63:0] pixels);
      logic [63:0] want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected output transaction %h", pixels);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (pixels[31:0] !== want[31:0]) begin
        $error("pixel_first expected %h actual %h", want[31:0], pixels[31:0]);
        errors++;
      end
      if (pixels[63:32] !== want[63:32]) begin
        $error("pixel_second expected %h actual %h", want[63:32], pixels[63:32]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  rgb_pair_scoreboard sb = new;
  int idle_cycles = 0;
  int burst_left = 0;
  bit no_gaps = 0;

  logic [15:0] ready_pattern = 16'h00ff;
  logic [1:0] stall_mode = '0;
  logic [7:0] stall_phase = '0;

  yuyv_to_rgb_pixel_pair_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_pair(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pixels(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls: always ready, a rotating pattern, or coin flips
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '0) begin
      stall_mode <= 2'($urandom_range(0, 2));
      ready_pattern <= 16'($urandom) | 16'h0001;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    case (stall_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ready_pattern[0];
      default: m_axis_tready <= 1'($urandom);
    endcase
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] pick_sample();
    logic [7:0] corner[6] = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd127};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pair(logic [31:0] yuyv);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 32'($urandom);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 32);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= yuyv;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // leaves the write enable high so that writes can follow back to back
  task automatic write_lane(logic [1:0] idx, yrgb_pkg::lane_t value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_lane(idx, value);
  endtask

  task automatic send_random_pairs(int count);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (count) send_pair({pick_sample(), pick_sample(), pick_sample(), pick_sample()});
  endtask

  initial begin
    // y0, cb, y1, cr from the lowest byte up
    logic [31:0] corner_pairs[16] = '{
      {8'd128, 8'd255, 8'd128, 8'd0}, {8'd0, 8'd0, 8'd0, 8'd0},
      {8'd255, 8'd255, 8'd255, 8'd255}, {8'd0, 8'd255, 8'd255, 8'd0},
      {8'd255, 8'd0, 8'd0, 8'd255}, {8'd128, 8'd128, 8'd128, 8'd128},
      {8'd255, 8'd0, 8'd128, 8'd255}, {8'd0, 8'd0, 8'd128, 8'd0},
      {8'd255, 8'd235, 8'd0, 8'd16}, {8'd0, 8'd0, 8'd255, 8'd255},
      {8'd255, 8'd255, 8'd0, 8'd0}, {8'd129, 8'd254, 8'd127, 8'd1},
      {8'd254, 8'd128, 8'd1, 8'd127}, {8'd200, 8'd50, 8'd60, 8'd200},
      {8'd128, 8'd0, 8'd255, 8'd0}, {8'd128, 8'd255, 8'd0, 8'd255}
    };
    yrgb_pkg::lane_t lane_sets[6][3] = '{
      '{2'd0, 2'd1, 2'd2}, '{2'd3, 2'd3, 2'd3}, '{2'd1, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd2}, '{2'd3, 2'd0, 2'd1}, '{2'd2, 2'd3, 2'd3}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    no_gaps = 1;
    foreach (corner_pairs[i]) send_pair(corner_pairs[i]);
    send_random_pairs(PAIRS_PER_PHASE);
    drain();

    foreach (lane_sets[p]) begin
      write_lane(yrgb_pkg::CFG_RED_LANE, lane_sets[p][0]);
      write_lane(yrgb_pkg::CFG_GREEN_LANE, lane_sets[p][1]);
      write_lane(yrgb_pkg::CFG_BLUE_LANE, lane_sets[p][2]);
      // out-of-range index must leave every lane alone
      if (p == 2) write_lane(CFG_IDX_UNUSED, 2'($urandom));
      cfg_we_i <= 1'b0;
      if (p == 1) foreach (corner_pairs[i]) send_pair(corner_pairs[i]);
      send_random_pairs(PAIRS_PER_PHASE);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
